@@ rtl/core/ipsv_pkg.sv @@
// shared types, constants and sine rom contents for the inverse park / svpwm block
package ipsv_pkg;

  localparam int ANGLE_STEPS  = 2048;
  localparam int FRAC_BITS    = 16;
  localparam int QUARTER_TURN = ANGLE_STEPS / 4;

  localparam int ANGLE_W   = $clog2(ANGLE_STEPS);
  localparam int VIN_W     = 19;
  localparam int SIN_W     = FRAC_BITS + 2;
  localparam int MUL_W     = VIN_W + SIN_W;
  localparam int VAB_W     = MUL_W - FRAC_BITS;
  localparam int COEF_W    = FRAC_BITS + 2;
  localparam int CPROD_W   = VAB_W + COEF_W;
  localparam int VAS_W     = VAB_W + FRAC_BITS;
  localparam int CMP_W     = CPROD_W + 1;
  localparam int FORM_W    = CPROD_W - FRAC_BITS;
  localparam int PERIOD_W  = 16;
  localparam int DEAD_W    = 8;
  localparam int DPROD_W   = PERIOD_W + FORM_W - 1;
  localparam int DUTY_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME  = CFG_IDX_W'(1);

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000);
  localparam logic [DEAD_W-1:0]   DEAD_RST   = DEAD_W'(10);

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;

  localparam longint C2_Q = (64'sd577350269190 <<< FRAC_BITS) / 64'sd1000000000000;
  localparam longint C3_Q = (64'sd11546 <<< FRAC_BITS) / 64'sd10000;
  localparam longint C4_Q = -((64'sd11547 <<< FRAC_BITS) / 64'sd10000);

  localparam logic signed [COEF_W-1:0] C2_COEF = COEF_W'(C2_Q);
  localparam logic signed [COEF_W-1:0] C3_COEF = COEF_W'(C3_Q);
  localparam logic signed [COEF_W-1:0] C4_COEF = COEF_W'(C4_Q);

  // series term divisors and their reciprocals scaled by 2^32, rounded down
  localparam longint unsigned TERM_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};
  localparam longint unsigned TERM_RCP [8] = '{(64'd1 << 32) / 64'd6,
                                               (64'd1 << 32) / 64'd20,
                                               (64'd1 << 32) / 64'd42,
                                               (64'd1 << 32) / 64'd72,
                                               (64'd1 << 32) / 64'd110,
                                               (64'd1 << 32) / 64'd156,
                                               (64'd1 << 32) / 64'd210,
                                               (64'd1 << 32) / 64'd272};

  typedef logic signed [SIN_W-1:0] sin_t;
  typedef sin_t sin_rom_t [ANGLE_STEPS];

  typedef enum logic [1:0] {
    SEC_CLAMP_C = 2'd0,
    SEC_CLAMP_A = 2'd1,
    SEC_CLAMP_B = 2'd2
  } sector_e;

  typedef struct packed {
    logic signed [VAB_W-1:0] va;
    logic signed [VAB_W-1:0] vb;
  } rot_t;

  typedef struct packed {
    sector_e                  sector;
    logic signed [FORM_W-1:0] form_x;
    logic signed [FORM_W-1:0] form_y;
  } sect_t;

  // taylor series sine in q30, rounded to the q format
  function automatic sin_t sine_entry(longint k);
    longint          x;
    longint          s;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned num;
    longint unsigned quo;
    bit              neg;
    x   = (TWO_PI_Q30 * k) >>> ANGLE_W;
    neg = 1'b0;
    if (x >= PI_Q30) begin
      x   = x - PI_Q30;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q30) begin
      x = PI_Q30 - x;
    end
    x2 = (unsigned'(x) * unsigned'(x)) >> 30;
    t  = unsigned'(x);
    s  = x;
    for (int n = 1; n <= 8; n++) begin
      num = (t * x2) >> 30;
      quo = (num * TERM_RCP[n-1]) >> 32;
      // the reciprocal estimate can fall short by one
      for (int j = 0; j < 2; j++) begin
        if (num - quo * TERM_DIV[n-1] >= TERM_DIV[n-1]) begin
          quo = quo + 64'd1;
        end
      end
      t = quo;
      if (n[0] == 1'b1) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    s = longint'((unsigned'(s) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    return neg ? SIN_W'(-s) : SIN_W'(s);
  endfunction

  function automatic sin_rom_t build_sine_rom();
    sin_rom_t r;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      r[k] = sine_entry(longint'(k));
    end
    return r;
  endfunction

  localparam sin_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ rtl/core/ipsv_rot.sv @@
// inverse park rotation: sine rom lookup, four products, va/vb sums
module ipsv_rot (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [ipsv_pkg::VIN_W-1:0]     vq_i,
  input  logic signed [ipsv_pkg::VIN_W-1:0]     vd_i,
  input  logic        [ipsv_pkg::ANGLE_W-1:0]   angle_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output ipsv_pkg::rot_t                        rot_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic [ipsv_pkg::ANGLE_W-1:0] kc;

  ipsv_pkg::sin_t                   sin_q, cos_q;
  logic signed [ipsv_pkg::VIN_W-1:0] vq_q, vd_q;

  logic signed [ipsv_pkg::MUL_W-1:0] p_dc_q, p_qs_q, p_ds_q, p_qc_q;
  ipsv_pkg::rot_t                    rot_q;

  assign en3 = !v3_q || ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  // cosine is the sine a quarter turn ahead, wrapping at the full turn
  assign kc = angle_i + ipsv_pkg::ANGLE_W'(ipsv_pkg::QUARTER_TURN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      sin_q <= ipsv_pkg::SINE_ROM[angle_i];
      cos_q <= ipsv_pkg::SINE_ROM[kc];
      vq_q  <= vq_i;
      vd_q  <= vd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      p_dc_q <= vd_q * cos_q;
      p_qs_q <= vq_q * sin_q;
      p_ds_q <= vd_q * sin_q;
      p_qc_q <= vq_q * cos_q;
    end
  end

  // upper bits of each product are the floor of the q-format product
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      rot_q.va <= $signed(p_dc_q[ipsv_pkg::MUL_W-1:ipsv_pkg::FRAC_BITS])
                - $signed(p_qs_q[ipsv_pkg::MUL_W-1:ipsv_pkg::FRAC_BITS]);
      rot_q.vb <= $signed(p_ds_q[ipsv_pkg::MUL_W-1:ipsv_pkg::FRAC_BITS])
                + $signed(p_qc_q[ipsv_pkg::MUL_W-1:ipsv_pkg::FRAC_BITS]);
    end
  end

  assign valid_o = v3_q;
  assign rot_o   = rot_q;

endmodule

@@ rtl/core/ipsv_sect.sv @@
// sector choice and the two active linear forms
module ipsv_sect (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  ipsv_pkg::rot_t  rot_i,
  output logic            valid_o,
  input  logic            ready_i,
  output ipsv_pkg::sect_t sect_o
);

  logic v4_q, v5_q;
  logic en4, en5;

  logic signed [ipsv_pkg::VAB_W-1:0]   va_q, vb_q;
  logic signed [ipsv_pkg::CPROD_W-1:0] p2_q, p3_q, p4_q;

  logic signed [ipsv_pkg::VAS_W-1:0]  vas;
  logic signed [ipsv_pkg::CMP_W-1:0]  vas_x, p2_x, cmp_sum;
  logic signed [ipsv_pkg::FORM_W-1:0] va_f, m2, m3, m4;
  ipsv_pkg::sect_t                    sect_d, sect_q;

  assign en5 = !v5_q || ready_i;
  assign en4 = !v4_q || en5;
  assign ready_o = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) v4_q <= valid_i;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && valid_i) begin
      va_q <= rot_i.va;
      vb_q <= rot_i.vb;
      p2_q <= ipsv_pkg::C2_COEF * rot_i.vb;
      p3_q <= ipsv_pkg::C3_COEF * rot_i.vb;
      p4_q <= ipsv_pkg::C4_COEF * rot_i.vb;
    end
  end

  assign vas     = {va_q, {ipsv_pkg::FRAC_BITS{1'b0}}};
  assign vas_x   = ipsv_pkg::CMP_W'(vas);
  assign p2_x    = ipsv_pkg::CMP_W'(p2_q);
  assign cmp_sum = vas_x + p2_x;

  assign va_f = ipsv_pkg::FORM_W'(va_q);
  assign m2   = $signed(p2_q[ipsv_pkg::CPROD_W-1:ipsv_pkg::FRAC_BITS]);
  assign m3   = $signed(p3_q[ipsv_pkg::CPROD_W-1:ipsv_pkg::FRAC_BITS]);
  assign m4   = $signed(p4_q[ipsv_pkg::CPROD_W-1:ipsv_pkg::FRAC_BITS]);

  always_comb begin
    if (vb_q > 0) begin
      // va > -c2*vb, compared exactly at full scale
      sect_d.sector = (cmp_sum > 0) ? ipsv_pkg::SEC_CLAMP_C : ipsv_pkg::SEC_CLAMP_A;
    end else begin
      sect_d.sector = (vas_x < p2_x) ? ipsv_pkg::SEC_CLAMP_A : ipsv_pkg::SEC_CLAMP_B;
    end
    case (sect_d.sector)
      ipsv_pkg::SEC_CLAMP_C: begin
        sect_d.form_x = va_f + m2;
        sect_d.form_y = m3;
      end
      ipsv_pkg::SEC_CLAMP_A: begin
        sect_d.form_x = m2 - va_f;
        sect_d.form_y = -va_f - m2;
      end
      default: begin
        sect_d.form_x = va_f - m2;
        sect_d.form_y = m4;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      sect_q <= sect_d;
    end
  end

  assign valid_o = v5_q;
  assign sect_o  = sect_q;

endmodule

@@ rtl/core/ipsv_duty.sv @@
// period scaling, dead-time offset, saturation and phase mapping
module ipsv_duty (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  ipsv_pkg::sect_t                    sect_i,
  input  logic [ipsv_pkg::PERIOD_W-1:0]      period_i,
  input  logic [ipsv_pkg::DEAD_W-1:0]        dead_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic [ipsv_pkg::DUTY_W-1:0]        duty_a_o,
  output logic [ipsv_pkg::DUTY_W-1:0]        duty_b_o,
  output logic [ipsv_pkg::DUTY_W-1:0]        duty_c_o,
  output ipsv_pkg::sector_e                  sector_o
);

  localparam int SUM_W = ipsv_pkg::DPROD_W - ipsv_pkg::FRAC_BITS + 1;

  logic v6_q, v7_q;
  logic en6, en7;

  ipsv_pkg::sector_e                  sec6_q;
  logic [ipsv_pkg::DPROD_W-1:0]       px_q, py_q;
  logic [ipsv_pkg::DPROD_W-1:0]       px_d, py_d;

  logic [SUM_W-1:0]                   sx, sy;
  logic [ipsv_pkg::DUTY_W-1:0]        dx, dy;
  logic [ipsv_pkg::DUTY_W-1:0]        da_q, db_q, dc_q;
  ipsv_pkg::sector_e                  sec7_q;

  assign en7 = !v7_q || !stall_i;
  assign en6 = !v6_q || en7;
  assign ready_o = en6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en6) v6_q <= valid_i;
      if (en7) v7_q <= v6_q;
    end
  end

  // a non-positive form gives no product
  always_comb begin
    px_d = '0;
    py_d = '0;
    if (sect_i.form_x > 0) begin
      px_d = period_i * sect_i.form_x[ipsv_pkg::FORM_W-2:0];
    end
    if (sect_i.form_y > 0) begin
      py_d = period_i * sect_i.form_y[ipsv_pkg::FORM_W-2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6 && valid_i) begin
      px_q   <= px_d;
      py_q   <= py_d;
      sec6_q <= sect_i.sector;
    end
  end

  assign sx = SUM_W'(px_q[ipsv_pkg::DPROD_W-1:ipsv_pkg::FRAC_BITS]) + SUM_W'(dead_i);
  assign sy = SUM_W'(py_q[ipsv_pkg::DPROD_W-1:ipsv_pkg::FRAC_BITS]) + SUM_W'(dead_i);
  assign dx = (sx > SUM_W'({ipsv_pkg::DUTY_W{1'b1}})) ? {ipsv_pkg::DUTY_W{1'b1}}
                                                       : sx[ipsv_pkg::DUTY_W-1:0];
  assign dy = (sy > SUM_W'({ipsv_pkg::DUTY_W{1'b1}})) ? {ipsv_pkg::DUTY_W{1'b1}}
                                                       : sy[ipsv_pkg::DUTY_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en7 && v6_q) begin
      sec7_q <= sec6_q;
      case (sec6_q)
        ipsv_pkg::SEC_CLAMP_C: begin
          da_q <= dx;
          db_q <= dy;
          dc_q <= '0;
        end
        ipsv_pkg::SEC_CLAMP_A: begin
          da_q <= '0;
          db_q <= dx;
          dc_q <= dy;
        end
        default: begin
          da_q <= dx;
          db_q <= '0;
          dc_q <= dy;
        end
      endcase
    end
  end

  assign valid_o  = v7_q;
  assign duty_a_o = da_q;
  assign duty_b_o = db_q;
  assign duty_c_o = dc_q;
  assign sector_o = sec7_q;

  a_clamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q |-> ((sec7_q == ipsv_pkg::SEC_CLAMP_C && dc_q == '0) ||
              (sec7_q == ipsv_pkg::SEC_CLAMP_A && da_q == '0) ||
              (sec7_q == ipsv_pkg::SEC_CLAMP_B && db_q == '0)))
    else $error("clamped phase duty not zero");

  a_dead_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && sec7_q == ipsv_pkg::SEC_CLAMP_C) |->
      (da_q >= ipsv_pkg::DUTY_W'(dead_i) && db_q >= ipsv_pkg::DUTY_W'(dead_i)))
    else $error("active duty below dead time");

  a_hold_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !en7) |=> (v6_q && $stable(px_q) && $stable(py_q)))
    else $error("stage product lost while blocked");

endmodule

@@ rtl/core/inverse_park_three_sector_svpwm.sv @@
// top level: config registers and the rotation, sector and duty pipeline
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word of q and d voltage
//   commands (signed Q3.16) and an 11-bit electrical angle. Output channel
//   (out_valid_o / out_stall_i) returns three phase duty counts and the
//   chosen sector. A word moves on a clock edge with valid high and stall low.
//   One word is accepted per cycle while the receiver does not stall; the
//   word passes through seven register stages (rom read, four products,
//   va/vb sums, coefficient products, sector and forms, period product,
//   offset and saturation), each holding one word.
//   Config channel (cfg_valid_i / cfg_ready_o) writes pwm_period at index 0
//   and dead_time_offset at index 1; other indexes are ignored. Write only
//   while the pipeline is empty.
//   Reset clears all stage valids and loads period 1000 and dead time 10.
//   When the receiver stalls, the output word holds and each stage keeps
//   its word once the stage after it is full; bubbles close up first, so
//   in_stall_o rises only when all seven stages hold words.
module inverse_park_three_sector_svpwm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ipsv_pkg::VIN_W-1:0]    vq_voltage_i,
  input  logic signed [ipsv_pkg::VIN_W-1:0]    vd_voltage_i,
  input  logic        [ipsv_pkg::ANGLE_W-1:0]  angle_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [ipsv_pkg::DUTY_W-1:0]   duty_a_o,
  output logic        [ipsv_pkg::DUTY_W-1:0]   duty_b_o,
  output logic        [ipsv_pkg::DUTY_W-1:0]   duty_c_o,
  output logic        [1:0]                    sector_id_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [ipsv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [ipsv_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  logic [ipsv_pkg::PERIOD_W-1:0] period_q;
  logic [ipsv_pkg::DEAD_W-1:0]   dead_q;

  logic            rot_valid, rot_ready, sect_valid, sect_ready, rot_in_ready;
  ipsv_pkg::rot_t  rot;
  ipsv_pkg::sect_t sect;
  ipsv_pkg::sector_e sector;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= ipsv_pkg::PERIOD_RST;
      dead_q   <= ipsv_pkg::DEAD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ipsv_pkg::REG_PWM_PERIOD: period_q <= cfg_data_i[ipsv_pkg::PERIOD_W-1:0];
        ipsv_pkg::REG_DEAD_TIME:  dead_q   <= cfg_data_i[ipsv_pkg::DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  ipsv_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (rot_in_ready),
    .vq_i    (vq_voltage_i),
    .vd_i    (vd_voltage_i),
    .angle_i (angle_index_i),
    .valid_o (rot_valid),
    .ready_i (rot_ready),
    .rot_o   (rot)
  );

  ipsv_sect u_sect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .rot_i   (rot),
    .valid_o (sect_valid),
    .ready_i (sect_ready),
    .sect_o  (sect)
  );

  ipsv_duty u_duty (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sect_valid),
    .ready_o  (sect_ready),
    .sect_i   (sect),
    .period_i (period_q),
    .dead_i   (dead_q),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .duty_a_o (duty_a_o),
    .duty_b_o (duty_b_o),
    .duty_c_o (duty_c_o),
    .sector_o (sector)
  );

  assign in_stall_o  = !rot_in_ready;
  assign sector_id_o = sector;

endmodule

@@ tb/svpwm_duty_checker.sv @@
`timescale 1ns / 1ps
// checker: predicts each duty word from the accepted commands and compares it with the dut
module svpwm_duty_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic signed [ipsv_pkg::VIN_W-1:0]     vq_voltage_i,
  input  logic signed [ipsv_pkg::VIN_W-1:0]     vd_voltage_i,
  input  logic        [ipsv_pkg::ANGLE_W-1:0]   angle_index_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic        [ipsv_pkg::DUTY_W-1:0]    duty_a_i,
  input  logic        [ipsv_pkg::DUTY_W-1:0]    duty_b_i,
  input  logic        [ipsv_pkg::DUTY_W-1:0]    duty_c_i,
  input  logic        [1:0]                     sector_id_i,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic        [ipsv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [ipsv_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output int                                    fail_count_o,
  output int                                    pending_o,
  output int                                    checked_o,
  output logic        [2:0]                     sectors_seen_o
);

  localparam int     STEPS = 2048;
  localparam int     FRAC  = 16;
  localparam longint PI_Q30_C      = 64'sd3373259426;
  localparam longint HALF_PI_Q30_C = 64'sd1686629713;
  localparam longint TWO_PI_Q30_C  = 64'sd6746518852;
  // coefficients truncated toward zero
  localparam longint K_C2 = (64'sd577350269190 * 64'sd65536) / 64'sd1000000000000;
  localparam longint K_C3 = (64'sd11546 * 64'sd65536) / 64'sd10000;
  localparam longint K_C4 = -((64'sd11547 * 64'sd65536) / 64'sd10000);

  typedef struct packed {
    logic [15:0]        a;
    logic [15:0]        b;
    logic [15:0]        c;
    ipsv_pkg::sector_e  sector;
  } duty_word_t;

  duty_word_t  duty_q [$];
  longint      sine_tab [STEPS];
  logic [15:0] period_q = 16'd1000;
  logic [7:0]  dead_q   = 8'd10;
  int          errs     = 0;
  int          checks   = 0;
  logic [2:0]  seen     = 3'b000;

  // taylor series in q30, folded into the first quadrant, rounded half up
  function automatic longint taylor_sine(longint k);
    longint          ang;
    longint          acc;
    longint unsigned ua;
    longint unsigned sq;
    longint unsigned term;
    bit              flip;
    ang  = (TWO_PI_Q30_C * k) / STEPS;
    flip = 1'b0;
    if (ang >= PI_Q30_C) begin
      ang  = ang - PI_Q30_C;
      flip = 1'b1;
    end
    if (ang > HALF_PI_Q30_C) begin
      ang = PI_Q30_C - ang;
    end
    ua   = ang;
    sq   = (ua * ua) >> 30;
    term = ua;
    acc  = ang;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * sq) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    return flip ? -acc : acc;
  endfunction

  function automatic longint qmul_floor(longint x, longint y);
    return (x * y) >>> FRAC;
  endfunction

  // negative products give only the dead time, large counts saturate
  function automatic logic [15:0] duty_count(longint form);
    longint per;
    longint prod;
    longint cnt;
    per  = period_q;
    prod = per * form;
    cnt  = (prod > 0) ? (prod >>> FRAC) : 64'sd0;
    cnt  = cnt + longint'(dead_q);
    if (cnt > 65535) begin
      cnt = 65535;
    end
    return cnt[15:0];
  endfunction

  function automatic duty_word_t svpwm_duties(logic signed [ipsv_pkg::VIN_W-1:0] vq_v,
                                              logic signed [ipsv_pkg::VIN_W-1:0] vd_v,
                                              logic [ipsv_pkg::ANGLE_W-1:0] ang);
    longint     q;
    longint     d;
    longint     s;
    longint     c;
    longint     va;
    longint     vb;
    longint     vas;
    duty_word_t w;
    q   = vq_v;
    d   = vd_v;
    s   = sine_tab[int'(ang) % STEPS];
    c   = sine_tab[(int'(ang) + STEPS / 4) % STEPS];
    va  = qmul_floor(d, c) - qmul_floor(q, s);
    vb  = qmul_floor(d, s) + qmul_floor(q, c);
    vas = va * 64'sd65536;
    w   = '0;
    if (vb > 0) begin
      w.sector = (vas > -(K_C2 * vb)) ? ipsv_pkg::SEC_CLAMP_C : ipsv_pkg::SEC_CLAMP_A;
    end else begin
      w.sector = (vas < K_C2 * vb) ? ipsv_pkg::SEC_CLAMP_A : ipsv_pkg::SEC_CLAMP_B;
    end
    case (w.sector)
      ipsv_pkg::SEC_CLAMP_C: begin
        w.a = duty_count(va + qmul_floor(K_C2, vb));
        w.b = duty_count(qmul_floor(K_C3, vb));
      end
      ipsv_pkg::SEC_CLAMP_A: begin
        w.b = duty_count(-va + qmul_floor(K_C2, vb));
        w.c = duty_count(-va - qmul_floor(K_C2, vb));
      end
      default: begin
        w.a = duty_count(va - qmul_floor(K_C2, vb));
        w.c = duty_count(qmul_floor(K_C4, vb));
      end
    endcase
    return w;
  endfunction

  initial begin
    for (int k = 0; k < STEPS; k++) begin
      sine_tab[k] = taylor_sine(longint'(k));
    end
  end

  always @(posedge clk_i) begin
    duty_word_t want;
    duty_word_t got;
    if (!rst_ni) begin
      period_q = 16'd1000;
      dead_q   = 8'd10;
      duty_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ipsv_pkg::REG_PWM_PERIOD: period_q = cfg_data_i[15:0];
          ipsv_pkg::REG_DEAD_TIME:  dead_q   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        duty_q.push_back(svpwm_duties(vq_voltage_i, vd_voltage_i, angle_index_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got.a      = duty_a_i;
        got.b      = duty_b_i;
        got.c      = duty_c_i;
        got.sector = ipsv_pkg::sector_e'(sector_id_i);
        if (duty_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%0t: unexpected duty word a=%0d b=%0d c=%0d sector=%0d",
                     $time, got.a, got.b, got.c, sector_id_i);
          end
        end else begin
          want = duty_q.pop_front();
          checks++;
          seen[want.sector] = 1'b1;
          if (want.a !== got.a || want.b !== got.b || want.c !== got.c ||
              want.sector !== got.sector) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: duty word %0d mismatch: expected a=%0d b=%0d c=%0d sector=%0d",
                       $time, checks, want.a, want.b, want.c, want.sector);
              $display("%0t:   got a=%0d b=%0d c=%0d sector=%0d",
                       $time, got.a, got.b, got.c, sector_id_i);
            end
          end
        end
      end
    end
    fail_count_o   <= errs;
    pending_o      <= duty_q.size();
    checked_o      <= checks;
    sectors_seen_o <= seen;
  end

endmodule

@@ tb/tb_inverse_park_three_sector_svpwm.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, command stimulus, register settings and the verdict
module tb_inverse_park_three_sector_svpwm;

  localparam int LIMIT_CYCLES    = 600000;
  localparam int DRAIN_CYCLES    = 21;
  localparam int WORDS_PER_PHASE = 330;
  localparam int N_PHASES        = 6;
  localparam int VW              = ipsv_pkg::VIN_W;
  localparam int AW              = ipsv_pkg::ANGLE_W;
  // indexes past the register list, writes there must be ignored
  localparam logic [ipsv_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [ipsv_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                                  clk_i         = 1'b0;
  logic                                  rst_ni        = 1'b0;
  logic                                  in_valid_i    = 1'b0;
  logic                                  in_stall_o;
  logic signed [VW-1:0]                  vq_voltage_i  = '0;
  logic signed [VW-1:0]                  vd_voltage_i  = '0;
  logic        [AW-1:0]                  angle_index_i = '0;
  logic                                  out_valid_o;
  logic                                  out_stall_i   = 1'b0;
  logic        [ipsv_pkg::DUTY_W-1:0]    duty_a_o;
  logic        [ipsv_pkg::DUTY_W-1:0]    duty_b_o;
  logic        [ipsv_pkg::DUTY_W-1:0]    duty_c_o;
  logic        [1:0]                     sector_id_o;
  logic                                  cfg_valid_i   = 1'b0;
  logic                                  cfg_ready_o;
  logic        [ipsv_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic        [ipsv_pkg::CFG_DAT_W-1:0] cfg_data_i    = '0;

  int         fail_count;
  int         pending;
  int         checked;
  logic [2:0] sectors_seen;
  int         cycle_count = 0;
  int         n_words     = 0;
  int         n_settings  = 0;
  int         stall_left  = 0;
  logic       quiet       = 1'b0;

  always #1 clk_i = ~clk_i;

  inverse_park_three_sector_svpwm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vq_voltage_i  (vq_voltage_i),
    .vd_voltage_i  (vd_voltage_i),
    .angle_index_i (angle_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .duty_a_o      (duty_a_o),
    .duty_b_o      (duty_b_o),
    .duty_c_o      (duty_c_o),
    .sector_id_o   (sector_id_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  svpwm_duty_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .vq_voltage_i   (vq_voltage_i),
    .vd_voltage_i   (vd_voltage_i),
    .angle_index_i  (angle_index_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_a_i       (duty_a_o),
    .duty_b_i       (duty_b_o),
    .duty_c_i       (duty_c_o),
    .sector_id_i    (sector_id_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .sectors_seen_o (sectors_seen)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d duty words still outstanding", cycle_count, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver back-pressure in random bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // valid stays high across back-to-back words, the caller lowers it
  task automatic send_word(input logic signed [VW-1:0] vq, input logic signed [VW-1:0] vd,
                           input logic [AW-1:0] ang);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    vq_voltage_i  <= vq;
    vd_voltage_i  <= vd;
    angle_index_i <= ang;
    do @(posedge clk_i); while (in_stall_o);
    n_words++;
  endtask

  task automatic write_reg(input logic [ipsv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ipsv_pkg::CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic random_word(output logic signed [VW-1:0] vq, output logic signed [VW-1:0] vd,
                             output logic [AW-1:0] ang);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      vq = VW'(int'($urandom_range(0, 262144)) - 131072);
      vd = VW'(int'($urandom_range(0, 262144)) - 131072);
    end else if (pick < 8) begin
      vq = VW'($urandom);
      vd = VW'($urandom);
    end else begin
      // tiny commands land on vb of zero and on sector borders
      vq = VW'(int'($urandom_range(0, 8)) - 4);
      vd = VW'(int'($urandom_range(0, 8)) - 4);
    end
    if ($urandom_range(0, 7) == 0) begin
      ang = AW'(512 * $urandom_range(0, 3) + $urandom_range(0, 2) + 2047);
    end else begin
      ang = AW'($urandom);
    end
  endtask

  task automatic directed_words();
    send_word('0, '0, '0);
    send_word(19'h3ffff, '0, '0);
    send_word(19'h40000, '0, '0);
    send_word('0, 19'h3ffff, '0);
    send_word('0, 19'h40000, '0);
    send_word(19'sd131072, 19'sd131072, 11'd256);
    send_word(-19'sd131072, -19'sd131072, 11'd256);
    send_word(19'sd131072, '0, 11'd512);
    send_word(19'sd131072, '0, 11'd1024);
    send_word(19'sd131072, '0, 11'd1536);
    send_word(19'sd131072, '0, 11'd2047);
    // vb of zero: sign of va picks the sector
    send_word('0, -19'sd100, '0);
    send_word('0, 19'sd100, '0);
    send_word('0, -19'sd1, '0);
    send_word('0, 19'sd1, '0);
    send_word('0, '0, 11'd1234);
    send_word(19'sd65536, '0, '0);
    send_word(-19'sd65536, '0, '0);
    send_word(19'sd65536, -19'sd131072, '0);
    send_word('0, -19'sd131072, 11'd1024);
    send_word(19'h40000, 19'h40000, 11'd1792);
    send_word(19'h3ffff, 19'h40000, 11'd333);
    send_word(19'sd1, 19'sd1, 11'd1);
    send_word(-19'sd1, -19'sd1, 11'd2046);
  endtask

  initial begin
    logic signed [VW-1:0] vq;
    logic signed [VW-1:0] vd;
    logic [AW-1:0]        ang;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();
    settle();
    n_settings++;
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(ipsv_pkg::REG_PWM_PERIOD, 16'hffff);
          write_reg(ipsv_pkg::REG_DEAD_TIME, {8'($urandom), 8'hff});
          write_reg(REG_SPARE_2, 16'($urandom));
        end
        1: begin
          write_reg(ipsv_pkg::REG_PWM_PERIOD, 16'h0000);
          write_reg(ipsv_pkg::REG_DEAD_TIME, 16'h0000);
        end
        2: begin
          write_reg(ipsv_pkg::REG_PWM_PERIOD, 16'h0001);
          write_reg(ipsv_pkg::REG_DEAD_TIME, {8'($urandom), 8'h80});
          write_reg(REG_SPARE_3, 16'($urandom));
        end
        3: begin
          write_reg(ipsv_pkg::REG_DEAD_TIME, 16'($urandom));
          write_reg(ipsv_pkg::REG_PWM_PERIOD, 16'($urandom));
        end
        4: begin
          write_reg(ipsv_pkg::REG_PWM_PERIOD, 16'h8000);
          write_reg(ipsv_pkg::REG_DEAD_TIME, 16'h0001);
        end
        default: begin
          write_reg(ipsv_pkg::REG_PWM_PERIOD, 16'd1000);
          write_reg(ipsv_pkg::REG_DEAD_TIME, 16'd10);
        end
      endcase
      cfg_valid_i <= 1'b0;
      n_settings++;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // last phase runs with no idling at all
        if (i % 64 == 0) begin
          quiet <= (p == N_PHASES - 1) || ($urandom_range(0, 3) == 0);
        end
        random_word(vq, vd, ang);
        send_word(vq, vd, ang);
      end
      settle();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d command words over %0d register settings, %0d duty words checked",
             n_words, n_settings, checked);
    $display("sectors reached (C,A,B clamp as bits 0..2): %b, failures %0d",
             sectors_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
